### rtl/core/bfdh_pkg.sv
package bfdh_pkg;

  localparam int HASH_W    = 32;
  localparam int HC_W      = 5;
  localparam int FB_W      = 11;
  localparam int NB_W      = FB_W + 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = FB_W;

  localparam int DEF_MAX_BYTES = 1024;

  localparam logic [HC_W-1:0] HC_RESET = 5'd6;
  localparam logic [HC_W-1:0] HC_MIN   = 5'd1;
  localparam logic [HC_W-1:0] HC_MAX   = 5'd30;
  localparam logic [FB_W-1:0] FB_RESET = 11'd1024;
  localparam logic [FB_W-1:0] FB_MIN   = 11'd8;

  localparam int ROT_AMT = 17;

  // Quotient bits resolved per divider cycle.
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = HASH_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_BYTES = 2'd1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_READ,
    ST_CHECK,
    ST_CLEAR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic take;
    logic load;
    logic set_content;
    logic clr_content;
    logic div_step;
    logic read;
    logic check;
    logic set_hit;
    logic sweep;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       empty;
    logic       has_content;
    logic       div_last;
    logic       last_probe;
    logic       bit_set;
    logic       sweep_last;
    logic       out_busy;
  } stat_t;

endpackage

### rtl/core/bfdh_ctrl.sv
module bfdh_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  bfdh_pkg::stat_t  stat,
  output bfdh_pkg::cmd_t   cmd
);

  bfdh_pkg::state_t state;
  bfdh_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfdh_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      bfdh_pkg::ST_INIT: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = bfdh_pkg::ST_IDLE;
        end
      end
      bfdh_pkg::ST_IDLE: begin
        cmd.take = 1'b1;
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = bfdh_pkg::ST_DECODE;
        end
      end
      bfdh_pkg::ST_DECODE: begin
        case (stat.op)
          bfdh_pkg::OP_INSERT: begin
            cmd.set_content = 1'b1;
            state_next      = bfdh_pkg::ST_DIV;
          end
          bfdh_pkg::OP_QUERY: begin
            // An empty key or an empty filter answers without probing.
            if (!stat.empty && stat.has_content) begin
              state_next = bfdh_pkg::ST_DIV;
            end else begin
              state_next = bfdh_pkg::ST_FINISH;
            end
          end
          bfdh_pkg::OP_CLEAR: begin
            cmd.clr_content = 1'b1;
            state_next      = bfdh_pkg::ST_CLEAR;
          end
          default: begin
            state_next = bfdh_pkg::ST_FINISH;
          end
        endcase
      end
      bfdh_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = bfdh_pkg::ST_READ;
        end
      end
      bfdh_pkg::ST_READ: begin
        cmd.read   = 1'b1;
        state_next = bfdh_pkg::ST_CHECK;
      end
      bfdh_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        if (stat.op == bfdh_pkg::OP_QUERY && !stat.bit_set) begin
          state_next = bfdh_pkg::ST_FINISH;
        end else if (stat.last_probe) begin
          cmd.set_hit = (stat.op == bfdh_pkg::OP_QUERY);
          state_next  = bfdh_pkg::ST_FINISH;
        end else begin
          state_next = bfdh_pkg::ST_DIV;
        end
      end
      bfdh_pkg::ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_next = bfdh_pkg::ST_FINISH;
        end
      end
      bfdh_pkg::ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = bfdh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bfdh_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !stat.out_busy)
    else $error("result issued while output register is held");

  a_read_after_div: assert property (@(posedge clk) disable iff (rst)
    state == bfdh_pkg::ST_READ |-> $past(state) == bfdh_pkg::ST_DIV && $past(stat.div_last))
    else $error("probe read started before remainder was complete");

  a_hit_needs_bit: assert property (@(posedge clk) disable iff (rst)
    cmd.set_hit |-> stat.bit_set && stat.last_probe)
    else $error("match flagged without all probe bits set");

  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(cmd.sweep && cmd.check))
    else $error("sweep and probe write in the same cycle");
`endif

endmodule

### rtl/core/bfdh_datapath.sv
module bfdh_datapath #(
  parameter int MAX_BYTES = bfdh_pkg::DEF_MAX_BYTES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bfdh_pkg::cmd_t                      cmd,
  output bfdh_pkg::stat_t                     stat,
  input  logic [1:0]                          operation,
  input  logic [bfdh_pkg::HASH_W-1:0]         key_hash,
  input  logic                                empty_key,
  input  logic                                cfg_write,
  input  logic [bfdh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bfdh_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                result_stall,
  output logic                                result_valid,
  output logic                                may_match
);

  localparam int AW      = $clog2(MAX_BYTES);
  localparam int FbLimit = (1 << bfdh_pkg::FB_W) - 1;
  localparam int ByteCap = (MAX_BYTES < FbLimit) ? MAX_BYTES : FbLimit;

  logic [bfdh_pkg::HC_W-1:0]      hash_count;
  logic [bfdh_pkg::FB_W-1:0]      filter_bytes;
  logic [bfdh_pkg::FB_W-1:0]      bytes_clamped;
  logic [bfdh_pkg::HC_W-1:0]      k_clamped;

  logic [1:0]                     op;
  logic                           empty;
  logic                           has_content;
  logic                           hit;
  logic [bfdh_pkg::HASH_W-1:0]    h;
  logic [bfdh_pkg::HASH_W-1:0]    h_next;
  logic [bfdh_pkg::HASH_W-1:0]    delta;
  logic [bfdh_pkg::HASH_W-1:0]    work;
  logic [bfdh_pkg::HASH_W-1:0]    work_next;
  logic [bfdh_pkg::NB_W-1:0]      nbits;
  logic [bfdh_pkg::NB_W-1:0]      rem;
  logic [bfdh_pkg::NB_W-1:0]      rem_next;
  logic [bfdh_pkg::NB_W:0]        trial;
  logic [bfdh_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [bfdh_pkg::HC_W-1:0]      probe_cnt;
  logic [bfdh_pkg::HC_W-1:0]      k;

  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  addr;
  logic [2:0]                     bitsel;
  logic [AW-1:0]                  sweep_addr;
  logic [7:0]                     rdata;
  logic [7:0]                     mem [MAX_BYTES];
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [7:0]                     mem_wdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_count   <= bfdh_pkg::HC_RESET;
      filter_bytes <= bfdh_pkg::FB_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bfdh_pkg::REG_HASH_COUNT:   hash_count   <= cfg_data[bfdh_pkg::HC_W-1:0];
        bfdh_pkg::REG_FILTER_BYTES: filter_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (filter_bytes < bfdh_pkg::FB_MIN) begin
      bytes_clamped = bfdh_pkg::FB_MIN;
    end else if (filter_bytes > bfdh_pkg::FB_W'(ByteCap)) begin
      bytes_clamped = bfdh_pkg::FB_W'(ByteCap);
    end else begin
      bytes_clamped = filter_bytes;
    end
    if (hash_count < bfdh_pkg::HC_MIN) begin
      k_clamped = bfdh_pkg::HC_MIN;
    end else if (hash_count > bfdh_pkg::HC_MAX) begin
      k_clamped = bfdh_pkg::HC_MAX;
    end else begin
      k_clamped = hash_count;
    end
  end

  // Restoring division, several quotient bits per cycle; only the remainder is kept.
  always_comb begin
    rem_next  = rem;
    work_next = work;
    trial     = '0;
    for (int i = 0; i < bfdh_pkg::DIV_BITS; i++) begin
      trial     = {rem_next, work_next[bfdh_pkg::HASH_W-1]};
      work_next = work_next << 1;
      if (trial >= {1'b0, nbits}) begin
        rem_next = bfdh_pkg::NB_W'(trial - {1'b0, nbits});
      end else begin
        rem_next = trial[bfdh_pkg::NB_W-1:0];
      end
    end
  end

  assign h_next  = h + delta;
  assign rd_addr = AW'(rem[bfdh_pkg::NB_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      has_content <= 1'b0;
      div_cnt     <= '0;
      probe_cnt   <= '0;
      sweep_addr  <= '0;
    end else begin
      if (cmd.set_content) begin
        has_content <= 1'b1;
      end else if (cmd.clr_content) begin
        has_content <= 1'b0;
      end
      if (cmd.load || cmd.check) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + 1'b1;
      end
      if (cmd.load) begin
        probe_cnt <= '0;
      end else if (cmd.check) begin
        probe_cnt <= probe_cnt + 1'b1;
      end
      if (cmd.sweep) begin
        if (stat.sweep_last) begin
          sweep_addr <= '0;
        end else begin
          sweep_addr <= sweep_addr + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= operation;
      empty <= empty_key;
      h     <= key_hash;
      work  <= key_hash;
      delta <= {key_hash[bfdh_pkg::ROT_AMT-1:0], key_hash[bfdh_pkg::HASH_W-1:bfdh_pkg::ROT_AMT]};
      rem   <= '0;
      nbits <= {bytes_clamped, 3'b000};
      k     <= k_clamped;
      hit   <= 1'b0;
    end else begin
      if (cmd.div_step) begin
        rem  <= rem_next;
        work <= work_next;
      end
      if (cmd.check) begin
        h    <= h_next;
        work <= h_next;
        rem  <= '0;
      end
      if (cmd.set_hit) begin
        hit <= 1'b1;
      end
    end
    if (cmd.read) begin
      addr   <= rd_addr;
      bitsel <= rem[2:0];
    end
  end

  // Bit store: one write and one registered read per cycle.
  always_comb begin
    mem_we    = cmd.sweep || (cmd.check && op == bfdh_pkg::OP_INSERT);
    mem_waddr = cmd.sweep ? sweep_addr : addr;
    mem_wdata = cmd.sweep ? 8'h00 : (rdata | (8'h01 << bitsel));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[rd_addr];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (cmd.emit) begin
      may_match <= hit;
    end
  end

  always_comb begin
    stat             = '0;
    stat.op          = op;
    stat.empty       = empty;
    stat.has_content = has_content;
    stat.div_last    = (div_cnt == bfdh_pkg::DIV_CNT_W'(bfdh_pkg::DIV_STEPS - 1));
    stat.last_probe  = (probe_cnt == k - 1'b1);
    stat.bit_set     = rdata[bitsel];
    stat.sweep_last  = (sweep_addr == AW'(MAX_BYTES - 1));
    stat.out_busy    = result_valid && result_stall;
  end

endmodule

### rtl/core/bloom_filter_double_hash.sv
// An accepted query or insert runs decode, then per probe the divider steps, one store read
// and one check (the divider resolves 4 quotient bits per step), then registers the result.
// One item at a time: no new item is taken until the result is issued; a query miss ends early.
// A clear sweeps all MAX_BYTES bytes of the bit store, one byte per cycle.
// Reset (synchronous, active high) restores the registers and then clears all MAX_BYTES bytes
// of the store, during which no item is taken; configuration writes still land.
module bloom_filter_double_hash #(
  parameter int MAX_BYTES = bfdh_pkg::DEF_MAX_BYTES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic [1:0]                       operation,
  input  logic [bfdh_pkg::HASH_W-1:0]      key_hash,
  input  logic                             empty_key,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             may_match,
  input  logic                             cfg_write,
  input  logic [bfdh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfdh_pkg::CFG_W-1:0]       cfg_data
);

  bfdh_pkg::cmd_t  cmd;
  bfdh_pkg::stat_t stat;

  bfdh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .stat       (stat),
    .cmd        (cmd)
  );

  bfdh_datapath #(
    .MAX_BYTES (MAX_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (operation),
    .key_hash     (key_hash),
    .empty_key    (empty_key),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .may_match    (may_match)
  );

  assign item_stall = !cmd.take;

endmodule
